FILE: hw/rtl/des_pkg.sv
// DES package: permutation tables, S-boxes, key rotation schedule and the
// combinational helpers built on them. No dependencies.
package des_pkg;

  // Left and right halves of the block as they move down the rounds
  typedef struct packed {
    logic [31:0] l;
    logic [31:0] r;
  } half_pair_t;

  typedef logic [47:0]       subkey_t;
  typedef logic [15:0][47:0] key_set_t;

  localparam int NUM_ROUNDS = 16;

  localparam logic [6:0] IP_TAB [64] = '{
    7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18, 7'd10, 7'd2,
    7'd60, 7'd52, 7'd44, 7'd36, 7'd28, 7'd20, 7'd12, 7'd4,
    7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22, 7'd14, 7'd6,
    7'd64, 7'd56, 7'd48, 7'd40, 7'd32, 7'd24, 7'd16, 7'd8,
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,  7'd1,
    7'd59, 7'd51, 7'd43, 7'd35, 7'd27, 7'd19, 7'd11, 7'd3,
    7'd61, 7'd53, 7'd45, 7'd37, 7'd29, 7'd21, 7'd13, 7'd5,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15, 7'd7
  };

  localparam logic [6:0] FP_TAB [64] = '{
    7'd40, 7'd8, 7'd48, 7'd16, 7'd56, 7'd24, 7'd64, 7'd32,
    7'd39, 7'd7, 7'd47, 7'd15, 7'd55, 7'd23, 7'd63, 7'd31,
    7'd38, 7'd6, 7'd46, 7'd14, 7'd54, 7'd22, 7'd62, 7'd30,
    7'd37, 7'd5, 7'd45, 7'd13, 7'd53, 7'd21, 7'd61, 7'd29,
    7'd36, 7'd4, 7'd44, 7'd12, 7'd52, 7'd20, 7'd60, 7'd28,
    7'd35, 7'd3, 7'd43, 7'd11, 7'd51, 7'd19, 7'd59, 7'd27,
    7'd34, 7'd2, 7'd42, 7'd10, 7'd50, 7'd18, 7'd58, 7'd26,
    7'd33, 7'd1, 7'd41, 7'd9,  7'd49, 7'd17, 7'd57, 7'd25
  };

  localparam logic [6:0] PC1_TAB [56] = '{
    7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
    7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
    7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
    7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
    7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
    7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
    7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
    7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
  };

  localparam logic [6:0] PC2_TAB [48] = '{
    7'd14, 7'd17, 7'd11, 7'd24, 7'd1,  7'd5,
    7'd3,  7'd28, 7'd15, 7'd6,  7'd21, 7'd10,
    7'd23, 7'd19, 7'd12, 7'd4,  7'd26, 7'd8,
    7'd16, 7'd7,  7'd27, 7'd20, 7'd13, 7'd2,
    7'd41, 7'd52, 7'd31, 7'd37, 7'd47, 7'd55,
    7'd30, 7'd40, 7'd51, 7'd45, 7'd33, 7'd48,
    7'd44, 7'd49, 7'd39, 7'd56, 7'd34, 7'd53,
    7'd46, 7'd42, 7'd50, 7'd36, 7'd29, 7'd32
  };

  localparam logic [6:0] E_TAB [48] = '{
    7'd32, 7'd1,  7'd2,  7'd3,  7'd4,  7'd5,
    7'd4,  7'd5,  7'd6,  7'd7,  7'd8,  7'd9,
    7'd8,  7'd9,  7'd10, 7'd11, 7'd12, 7'd13,
    7'd12, 7'd13, 7'd14, 7'd15, 7'd16, 7'd17,
    7'd16, 7'd17, 7'd18, 7'd19, 7'd20, 7'd21,
    7'd20, 7'd21, 7'd22, 7'd23, 7'd24, 7'd25,
    7'd24, 7'd25, 7'd26, 7'd27, 7'd28, 7'd29,
    7'd28, 7'd29, 7'd30, 7'd31, 7'd32, 7'd1
  };

  localparam logic [6:0] P_TAB [32] = '{
    7'd16, 7'd7,  7'd20, 7'd21, 7'd29, 7'd12, 7'd28, 7'd17,
    7'd1,  7'd15, 7'd23, 7'd26, 7'd5,  7'd18, 7'd31, 7'd10,
    7'd2,  7'd8,  7'd24, 7'd14, 7'd32, 7'd27, 7'd3,  7'd9,
    7'd19, 7'd13, 7'd30, 7'd6,  7'd22, 7'd11, 7'd4,  7'd25
  };

  // Per-round left rotation of the C and D key halves
  localparam logic [1:0] ROT_TAB [16] = '{
    2'd1, 2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2,
    2'd1, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd2, 2'd1
  };

  localparam logic [3:0] S_TAB [8][4][16] = '{
    '{'{4'd14, 4'd4, 4'd13, 4'd1, 4'd2, 4'd15, 4'd11, 4'd8,
        4'd3, 4'd10, 4'd6, 4'd12, 4'd5, 4'd9, 4'd0, 4'd7},
      '{4'd0, 4'd15, 4'd7, 4'd4, 4'd14, 4'd2, 4'd13, 4'd1,
        4'd10, 4'd6, 4'd12, 4'd11, 4'd9, 4'd5, 4'd3, 4'd8},
      '{4'd4, 4'd1, 4'd14, 4'd8, 4'd13, 4'd6, 4'd2, 4'd11,
        4'd15, 4'd12, 4'd9, 4'd7, 4'd3, 4'd10, 4'd5, 4'd0},
      '{4'd15, 4'd12, 4'd8, 4'd2, 4'd4, 4'd9, 4'd1, 4'd7,
        4'd5, 4'd11, 4'd3, 4'd14, 4'd10, 4'd0, 4'd6, 4'd13}},
    '{'{4'd15, 4'd1, 4'd8, 4'd14, 4'd6, 4'd11, 4'd3, 4'd4,
        4'd9, 4'd7, 4'd2, 4'd13, 4'd12, 4'd0, 4'd5, 4'd10},
      '{4'd3, 4'd13, 4'd4, 4'd7, 4'd15, 4'd2, 4'd8, 4'd14,
        4'd12, 4'd0, 4'd1, 4'd10, 4'd6, 4'd9, 4'd11, 4'd5},
      '{4'd0, 4'd14, 4'd7, 4'd11, 4'd10, 4'd4, 4'd13, 4'd1,
        4'd5, 4'd8, 4'd12, 4'd6, 4'd9, 4'd3, 4'd2, 4'd15},
      '{4'd13, 4'd8, 4'd10, 4'd1, 4'd3, 4'd15, 4'd4, 4'd2,
        4'd11, 4'd6, 4'd7, 4'd12, 4'd0, 4'd5, 4'd14, 4'd9}},
    '{'{4'd10, 4'd0, 4'd9, 4'd14, 4'd6, 4'd3, 4'd15, 4'd5,
        4'd1, 4'd13, 4'd12, 4'd7, 4'd11, 4'd4, 4'd2, 4'd8},
      '{4'd13, 4'd7, 4'd0, 4'd9, 4'd3, 4'd4, 4'd6, 4'd10,
        4'd2, 4'd8, 4'd5, 4'd14, 4'd12, 4'd11, 4'd15, 4'd1},
      '{4'd13, 4'd6, 4'd4, 4'd9, 4'd8, 4'd15, 4'd3, 4'd0,
        4'd11, 4'd1, 4'd2, 4'd12, 4'd5, 4'd10, 4'd14, 4'd7},
      '{4'd1, 4'd10, 4'd13, 4'd0, 4'd6, 4'd9, 4'd8, 4'd7,
        4'd4, 4'd15, 4'd14, 4'd3, 4'd11, 4'd5, 4'd2, 4'd12}},
    '{'{4'd7, 4'd13, 4'd14, 4'd3, 4'd0, 4'd6, 4'd9, 4'd10,
        4'd1, 4'd2, 4'd8, 4'd5, 4'd11, 4'd12, 4'd4, 4'd15},
      '{4'd13, 4'd8, 4'd11, 4'd5, 4'd6, 4'd15, 4'd0, 4'd3,
        4'd4, 4'd7, 4'd2, 4'd12, 4'd1, 4'd10, 4'd14, 4'd9},
      '{4'd10, 4'd6, 4'd9, 4'd0, 4'd12, 4'd11, 4'd7, 4'd13,
        4'd15, 4'd1, 4'd3, 4'd14, 4'd5, 4'd2, 4'd8, 4'd4},
      '{4'd3, 4'd15, 4'd0, 4'd6, 4'd10, 4'd1, 4'd13, 4'd8,
        4'd9, 4'd4, 4'd5, 4'd11, 4'd12, 4'd7, 4'd2, 4'd14}},
    '{'{4'd2, 4'd12, 4'd4, 4'd1, 4'd7, 4'd10, 4'd11, 4'd6,
        4'd8, 4'd5, 4'd3, 4'd15, 4'd13, 4'd0, 4'd14, 4'd9},
      '{4'd14, 4'd11, 4'd2, 4'd12, 4'd4, 4'd7, 4'd13, 4'd1,
        4'd5, 4'd0, 4'd15, 4'd10, 4'd3, 4'd9, 4'd8, 4'd6},
      '{4'd4, 4'd2, 4'd1, 4'd11, 4'd10, 4'd13, 4'd7, 4'd8,
        4'd15, 4'd9, 4'd12, 4'd5, 4'd6, 4'd3, 4'd0, 4'd14},
      '{4'd11, 4'd8, 4'd12, 4'd7, 4'd1, 4'd14, 4'd2, 4'd13,
        4'd6, 4'd15, 4'd0, 4'd9, 4'd10, 4'd4, 4'd5, 4'd3}},
    '{'{4'd12, 4'd1, 4'd10, 4'd15, 4'd9, 4'd2, 4'd6, 4'd8,
        4'd0, 4'd13, 4'd3, 4'd4, 4'd14, 4'd7, 4'd5, 4'd11},
      '{4'd10, 4'd15, 4'd4, 4'd2, 4'd7, 4'd12, 4'd9, 4'd5,
        4'd6, 4'd1, 4'd13, 4'd14, 4'd0, 4'd11, 4'd3, 4'd8},
      '{4'd9, 4'd14, 4'd15, 4'd5, 4'd2, 4'd8, 4'd12, 4'd3,
        4'd7, 4'd0, 4'd4, 4'd10, 4'd1, 4'd13, 4'd11, 4'd6},
      '{4'd4, 4'd3, 4'd2, 4'd12, 4'd9, 4'd5, 4'd15, 4'd10,
        4'd11, 4'd14, 4'd1, 4'd7, 4'd6, 4'd0, 4'd8, 4'd13}},
    '{'{4'd4, 4'd11, 4'd2, 4'd14, 4'd15, 4'd0, 4'd8, 4'd13,
        4'd3, 4'd12, 4'd9, 4'd7, 4'd5, 4'd10, 4'd6, 4'd1},
      '{4'd13, 4'd0, 4'd11, 4'd7, 4'd4, 4'd9, 4'd1, 4'd10,
        4'd14, 4'd3, 4'd5, 4'd12, 4'd2, 4'd15, 4'd8, 4'd6},
      '{4'd1, 4'd4, 4'd11, 4'd13, 4'd12, 4'd3, 4'd7, 4'd14,
        4'd10, 4'd15, 4'd6, 4'd8, 4'd0, 4'd5, 4'd9, 4'd2},
      '{4'd6, 4'd11, 4'd13, 4'd8, 4'd1, 4'd4, 4'd10, 4'd7,
        4'd9, 4'd5, 4'd0, 4'd15, 4'd14, 4'd2, 4'd3, 4'd12}},
    '{'{4'd13, 4'd2, 4'd8, 4'd4, 4'd6, 4'd15, 4'd11, 4'd1,
        4'd10, 4'd9, 4'd3, 4'd14, 4'd5, 4'd0, 4'd12, 4'd7},
      '{4'd1, 4'd15, 4'd13, 4'd8, 4'd10, 4'd3, 4'd7, 4'd4,
        4'd12, 4'd5, 4'd6, 4'd11, 4'd0, 4'd14, 4'd9, 4'd2},
      '{4'd7, 4'd11, 4'd4, 4'd1, 4'd9, 4'd12, 4'd14, 4'd2,
        4'd0, 4'd6, 4'd10, 4'd13, 4'd15, 4'd3, 4'd5, 4'd8},
      '{4'd2, 4'd1, 4'd14, 4'd7, 4'd4, 4'd10, 4'd8, 4'd13,
        4'd15, 4'd12, 4'd9, 4'd0, 4'd3, 4'd5, 4'd6, 4'd11}}
  };

  // Tables count bits from 1 at the MSB of the source word
  function automatic logic [63:0] perm_ip(logic [63:0] x);
    logic [63:0] r;
    for (int k = 0; k < 64; k++) begin
      r[63-k] = x[6'(64 - int'(IP_TAB[k]))];
    end
    return r;
  endfunction

  function automatic logic [63:0] perm_fp(logic [63:0] x);
    logic [63:0] r;
    for (int k = 0; k < 64; k++) begin
      r[63-k] = x[6'(64 - int'(FP_TAB[k]))];
    end
    return r;
  endfunction

  function automatic logic [55:0] perm_pc1(logic [63:0] x);
    logic [55:0] r;
    for (int k = 0; k < 56; k++) begin
      r[55-k] = x[6'(64 - int'(PC1_TAB[k]))];
    end
    return r;
  endfunction

  function automatic logic [47:0] perm_pc2(logic [55:0] x);
    logic [47:0] r;
    for (int k = 0; k < 48; k++) begin
      r[47-k] = x[6'(56 - int'(PC2_TAB[k]))];
    end
    return r;
  endfunction

  function automatic logic [47:0] perm_e(logic [31:0] x);
    logic [47:0] r;
    for (int k = 0; k < 48; k++) begin
      r[47-k] = x[5'(32 - int'(E_TAB[k]))];
    end
    return r;
  endfunction

  function automatic logic [31:0] perm_p(logic [31:0] x);
    logic [31:0] r;
    for (int k = 0; k < 32; k++) begin
      r[31-k] = x[5'(32 - int'(P_TAB[k]))];
    end
    return r;
  endfunction

  // Total rotation applied to C and D up to and including round rnd
  function automatic int rot_total(int rnd);
    int s;
    s = 0;
    for (int i = 0; i < NUM_ROUNDS; i++) begin
      if (i <= rnd) s = s + int'(ROT_TAB[i]);
    end
    return s;
  endfunction

  function automatic logic [27:0] rotl28(logic [27:0] v, int s);
    return (v << s) | (v >> (28 - s));
  endfunction

  // Round function: expand, mix key, substitute, permute
  function automatic logic [31:0] feistel(logic [31:0] r, subkey_t k);
    logic [47:0] x;
    logic [5:0]  b;
    logic [31:0] s;
    x = perm_e(r) ^ k;
    s = '0;
    for (int i = 0; i < 8; i++) begin
      b = x[47-6*i -: 6];
      s[31-4*i -: 4] = S_TAB[i][{b[5], b[0]}][b[4:1]];
    end
    return perm_p(s);
  endfunction

endpackage

FILE: hw/rtl/des_key_sched.sv
// DES key register and round key schedule (PC-1, rotations, PC-2).
// Depends on des_pkg.
module des_key_sched (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [63:0]       cfg_wdata,
  output des_pkg::key_set_t round_keys
);
  import des_pkg::*;

  logic [63:0] key_r;
  logic [63:0] key_nxt;
  logic [55:0] cd;

  // Take a new key on a write, hold otherwise
  always_comb begin
    key_nxt = cfg_we ? cfg_wdata : key_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= '0;
    end else begin
      key_r <= key_nxt;
    end
  end

  assign cd = perm_pc1(key_r);

  // Each round key is the PC-2 of C and D rotated by the running total
  for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_key
    assign round_keys[g] = perm_pc2({rotl28(cd[55:28], rot_total(g)),
                                     rotl28(cd[27:0], rot_total(g))});
  end

endmodule

FILE: hw/rtl/des_round.sv
// One registered Feistel round of the DES pipeline.
// Depends on des_pkg.
module des_round (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  des_pkg::half_pair_t in_data,
  input  des_pkg::subkey_t    round_key,
  output logic                out_valid,
  output des_pkg::half_pair_t out_data
);
  import des_pkg::*;

  logic       valid_r;
  half_pair_t data_r;
  half_pair_t data_nxt;

  // Swap halves and mix the round function into the new right half
  always_comb begin
    data_nxt.l = in_data.r;
    data_nxt.r = in_data.l ^ feistel(in_data.r, round_key);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

FILE: hw/rtl/des_block_encrypt.sv
// DES block encryption top level: IP stage, sixteen round stages, FP stage.
// Depends on des_pkg, des_key_sched and des_round.
//
//   channel   ports                           handshake
//   input     in_plain_block                  start & ~busy
//   result    out_cipher_block                out_valid (one-cycle strobe)
//   config    cfg_wdata                       cfg_we
//
// One item enters per cycle; its result passes through one IP register,
// one register per round and one FP register.
// Reset clears the valid bits and the key to zero.
// busy stays low: every stage advances each cycle and the receiver cannot
// stall, so nothing is held back.
module des_block_encrypt (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [63:0] in_plain_block,
  output logic        out_valid,
  output logic [63:0] out_cipher_block,
  input  logic        cfg_we,
  input  logic [63:0] cfg_wdata
);
  import des_pkg::*;

  key_set_t   round_keys;
  logic       stg_valid [NUM_ROUNDS+1];
  half_pair_t stg_data  [NUM_ROUNDS+1];

  logic       ip_valid_r;
  half_pair_t ip_data_r;
  logic       out_valid_r;
  logic [63:0] out_block_r;
  logic [63:0] out_block_nxt;

  assign busy = 1'b0;

  des_key_sched u_key_sched (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .round_keys (round_keys)
  );

  // Initial permutation stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ip_valid_r <= 1'b0;
    end else begin
      ip_valid_r <= start & ~busy;
    end
  end

  always_ff @(posedge clk) begin
    ip_data_r <= perm_ip(in_plain_block);
  end

  assign stg_valid[0] = ip_valid_r;
  assign stg_data[0]  = ip_data_r;

  // Round stages
  for (genvar g = 0; g < NUM_ROUNDS; g++) begin : g_round
    des_round u_round (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (stg_valid[g]),
      .in_data   (stg_data[g]),
      .round_key (round_keys[g]),
      .out_valid (stg_valid[g+1]),
      .out_data  (stg_data[g+1])
    );
  end

  // Swap halves and apply the inverse permutation
  assign out_block_nxt = perm_fp({stg_data[NUM_ROUNDS].r, stg_data[NUM_ROUNDS].l});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= stg_valid[NUM_ROUNDS];
    end
  end

  always_ff @(posedge clk) begin
    out_block_r <= out_block_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_cipher_block = out_block_r;

endmodule
